// File: src/sgs_pkg.sv
// ============================================================================
// sgs_pkg - shared types and coefficient tables for the smoother
// Word layouts of both channels, window register constants and the
// quadratic smoothing coefficients for windows of 5 to 25 points.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sgs_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int MAX_HALF_DEF = 12;
	localparam int WIN_W        = 6;
	localparam int ROWS         = 11;
	localparam int TAPS         = 13;
	localparam int ROW_W        = 4;
	localparam int TAP_W        = 4;
	localparam int COEF_W       = 10;
	localparam int NORM_W       = 13;
	localparam int RCP_SHIFT    = 29;
	localparam int RCP_W        = 25;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(7);
	localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(5);
	localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(26);
	localparam logic [ROW_W-1:0] ROW_5PT   = ROW_W'(0);
	localparam logic [ROW_W-1:0] ROW_7PT   = ROW_W'(1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       block_end;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smoothed;
		logic                       last_out;
	} out_word_t;

	// centre coefficient first, then one per tap pair
	localparam int SG_COEF [ROWS][TAPS] = '{
		'{ 17,  12,  -3,   0,   0,   0,   0,   0,   0,   0,   0,    0,    0},
		'{  7,   6,   3,  -2,   0,   0,   0,   0,   0,   0,   0,    0,    0},
		'{ 59,  54,  39,  14, -21,   0,   0,   0,   0,   0,   0,    0,    0},
		'{ 89,  84,  69,  44,   9, -36,   0,   0,   0,   0,   0,    0,    0},
		'{ 25,  24,  21,  16,   9,   0, -11,   0,   0,   0,   0,    0,    0},
		'{167, 162, 147, 122,  87,  42, -13, -78,   0,   0,   0,    0,    0},
		'{ 43,  42,  39,  34,  27,  18,   7,  -6, -21,   0,   0,    0,    0},
		'{269, 264, 249, 224, 189, 144,  89,  24, -51,-136,   0,    0,    0},
		'{329, 324, 309, 284, 249, 204, 149,  84,   9, -76,-171,    0,    0},
		'{ 79,  78,  75,  70,  63,  54,  43,  30,  15,  -2, -21,  -42,    0},
		'{467, 462, 447, 422, 387, 342, 287, 222, 147,  62, -33, -138, -253}
	};

	localparam int SG_NORM [ROWS] = '{
		35, 21, 231, 429, 143, 1105, 323, 2261, 3059, 805, 5175
	};

	// floor(2^RCP_SHIFT / norm); for a magnitude below 2^RCP_SHIFT the scaled
	// product is the true quotient or one below it
	localparam int SG_RECIP [ROWS] = '{
		(1 << RCP_SHIFT) / 35,   (1 << RCP_SHIFT) / 21,   (1 << RCP_SHIFT) / 231,
		(1 << RCP_SHIFT) / 429,  (1 << RCP_SHIFT) / 143,  (1 << RCP_SHIFT) / 1105,
		(1 << RCP_SHIFT) / 323,  (1 << RCP_SHIFT) / 2261, (1 << RCP_SHIFT) / 3059,
		(1 << RCP_SHIFT) / 805,  (1 << RCP_SHIFT) / 5175
	};

	function automatic logic signed [COEF_W-1:0] sg_coef(
		input logic [ROW_W-1:0] row,
		input logic [TAP_W-1:0] tap
	);
		return COEF_W'(SG_COEF[row][tap]);
	endfunction

	function automatic logic [NORM_W-1:0] sg_norm(input logic [ROW_W-1:0] row);
		return NORM_W'(SG_NORM[row]);
	endfunction

	function automatic logic [RCP_W-1:0] sg_recip(input logic [ROW_W-1:0] row);
		return RCP_W'(SG_RECIP[row]);
	endfunction

endpackage

`default_nettype wire

// File: src/sgs_ram.sv
// ============================================================================
// sgs_ram - generic dual read port RAM
// One write port, two read ports with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sgs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 25
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output      logic [WIDTH-1:0]         rdata_a,
	output      logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// File: src/savitzky_golay_smoother_top.sv
// ============================================================================
// savitzky_golay_smoother_top - quadratic smoothing filter for sample blocks
// Microcoded sequencer over a circular sample RAM, one multiply-accumulate
// unit and a reciprocal multiply divider.
// ============================================================================
//
//  channel   | dir | handshake                  | word
//  ----------+-----+----------------------------+----------------------------
//  feed      | in  | feed_valid / feed_stall    | in_word_t  sample, block_end
//  result    | out | result_valid / result_stall| out_word_t smoothed, last_out
//  cfg       | in  | cfg_wen (no wait)          | cfg_wdata  window_size
//
//  per feed word: a ramp-up word is only classified, a raw edge sample is
//  read and emitted, a smoothed sample runs the tap loop and then the divide
//  (init, multiply, estimate, fix); a block end then flushes sample by sample.
//  one word at a time: feed_stall is low only in the idle step.
//  reset clears the sequencer, pointers and counts; the sample RAM needs no
//  clearing because only samples of the current block are ever read.
//  result_stall holds the sequencer at an emit step until the output
//  register frees up; the register accepts a new word in the cycle it drains.
//
`timescale 1ns / 1ps
`default_nettype none

module savitzky_golay_smoother_top
	import sgs_pkg::*;
#(
	parameter int MAX_HALF = MAX_HALF_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire in_word_t         feed,
	input  wire logic             feed_valid,
	output      logic             feed_stall,
	output      out_word_t        result,
	output      logic             result_valid,
	input  wire logic             result_stall,
	input  wire logic             cfg_wen,
	input  wire logic [WIN_W-1:0] cfg_wdata
);

	localparam int DEPTH   = 2 * MAX_HALF + 1;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int H_W     = $clog2(MAX_HALF + 1);
	localparam int PAIR_W  = SAMPLE_W + 1;
	localparam int PROD_W  = PAIR_W + COEF_W;
	localparam int ACC_W   = SAMPLE_W + 14;
	localparam int RCP_P_W = ACC_W + RCP_W;

	localparam logic [ROW_W-1:0] ROW_FALLBACK = (MAX_HALF >= 3) ? ROW_7PT : ROW_5PT;
	localparam logic [H_W-1:0]   H_RESET      = H_W'(int'(ROW_FALLBACK) + 2);
	localparam logic [IDX_W-1:0] POS_MAX      = IDX_W'(2 * MAX_HALF);

	localparam logic signed [SAMPLE_W-1:0] SAT_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAT_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// ---------------------------------------------------------------------
	// microcode program
	// ---------------------------------------------------------------------
	typedef enum logic [4:0] {
		ST_IDLE, ST_CLASS, ST_MAC_INIT, ST_MAC, ST_DRAIN, ST_DIV_INIT,
		ST_DIV, ST_DIV_EST, ST_DIV_FIX, ST_EMIT_Q, ST_FLUSH_SETUP, ST_FLUSH_RD,
		ST_FLUSH_EMIT, ST_FLUSH_NEXT, ST_DONE, ST_EDGE_RD, ST_EDGE_EMIT,
		ST_EDGE_DONE
	} step_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_ACCEPT, OP_MAC_INIT, OP_MAC, OP_DIV_INIT, OP_DIV,
		OP_DIV_EST, OP_DIV_FIX, OP_EMIT_Q, OP_FLUSH_INIT, OP_EMIT_RAW, OP_F_DEC
	} op_t;

	typedef enum logic [3:0] {
		C_NONE, C_ALWAYS, C_NO_ACCEPT, C_K_LT_H, C_K_LT_2H, C_J_NZ,
		C_PIPE_BUSY, C_OUT_BUSY, C_NOT_END, C_F_NZ
	} cond_t;

	typedef enum logic [1:0] {AS_TAP, AS_EDGE, AS_FLUSH} asel_t;

	typedef enum logic {LS_ZERO, LS_F_ZERO} lsel_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		asel_t asel;
		lsel_t lsel;
	} ctrl_t;

	function automatic ctrl_t rom(input step_t s);
		ctrl_t w;
		w = '{op: OP_NOP, cond: C_NONE, target: ST_IDLE, asel: AS_TAP, lsel: LS_ZERO};
		unique case (s)
			ST_IDLE:        w = '{OP_ACCEPT,     C_NO_ACCEPT, ST_IDLE,        AS_TAP,   LS_ZERO};
			ST_CLASS:       w = '{OP_NOP,        C_K_LT_H,    ST_FLUSH_SETUP, AS_TAP,   LS_ZERO};
			ST_MAC_INIT:    w = '{OP_MAC_INIT,   C_K_LT_2H,   ST_EDGE_RD,     AS_TAP,   LS_ZERO};
			ST_MAC:         w = '{OP_MAC,        C_J_NZ,      ST_MAC,         AS_TAP,   LS_ZERO};
			ST_DRAIN:       w = '{OP_NOP,        C_PIPE_BUSY, ST_DRAIN,       AS_TAP,   LS_ZERO};
			ST_DIV_INIT:    w = '{OP_DIV_INIT,   C_NONE,      ST_IDLE,        AS_TAP,   LS_ZERO};
			ST_DIV:         w = '{OP_DIV,        C_NONE,      ST_IDLE,        AS_TAP,   LS_ZERO};
			ST_DIV_EST:     w = '{OP_DIV_EST,    C_NONE,      ST_IDLE,        AS_TAP,   LS_ZERO};
			ST_DIV_FIX:     w = '{OP_DIV_FIX,    C_NONE,      ST_IDLE,        AS_TAP,   LS_ZERO};
			ST_EMIT_Q:      w = '{OP_EMIT_Q,     C_OUT_BUSY,  ST_EMIT_Q,      AS_TAP,   LS_ZERO};
			ST_FLUSH_SETUP: w = '{OP_FLUSH_INIT, C_NOT_END,   ST_IDLE,        AS_FLUSH, LS_ZERO};
			ST_FLUSH_RD:    w = '{OP_NOP,        C_NONE,      ST_IDLE,        AS_FLUSH, LS_ZERO};
			ST_FLUSH_EMIT:  w = '{OP_EMIT_RAW,   C_OUT_BUSY,  ST_FLUSH_EMIT,  AS_FLUSH, LS_F_ZERO};
			ST_FLUSH_NEXT:  w = '{OP_F_DEC,      C_F_NZ,      ST_FLUSH_RD,    AS_FLUSH, LS_ZERO};
			ST_DONE:        w = '{OP_NOP,        C_ALWAYS,    ST_IDLE,        AS_FLUSH, LS_ZERO};
			ST_EDGE_RD:     w = '{OP_NOP,        C_NONE,      ST_IDLE,        AS_EDGE,  LS_ZERO};
			ST_EDGE_EMIT:   w = '{OP_EMIT_RAW,   C_OUT_BUSY,  ST_EDGE_EMIT,   AS_EDGE,  LS_ZERO};
			ST_EDGE_DONE:   w = '{OP_NOP,        C_ALWAYS,    ST_FLUSH_SETUP, AS_EDGE,  LS_ZERO};
			default:        w = '{OP_NOP,        C_ALWAYS,    ST_IDLE,        AS_TAP,   LS_ZERO};
		endcase
		return w;
	endfunction

	// circular index: delay tap i lives at (newest - i) mod DEPTH
	function automatic logic [IDX_W-1:0] wrap_sub(
		input logic [IDX_W-1:0] p,
		input logic [IDX_W-1:0] i
	);
		logic [IDX_W:0] d;
		d = {1'b0, p} - {1'b0, i};
		if (d[IDX_W]) begin
			d = d + (IDX_W+1)'(DEPTH);
		end
		return d[IDX_W-1:0];
	endfunction

	// ---------------------------------------------------------------------
	// state
	// ---------------------------------------------------------------------
	step_t                     step_q;
	logic [WIN_W-1:0]          win_q;
	logic [ROW_W-1:0]          row_q;
	logic [H_W-1:0]            h_q;
	logic [IDX_W-1:0]          pos_q;     // position in block, saturating
	logic [IDX_W-1:0]          k_q;       // position of the word in flight
	logic                      end_q;
	logic [IDX_W-1:0]          wp_q;      // RAM address of the newest sample
	logic [H_W-1:0]            j_q;       // tap pair counter
	logic [IDX_W-1:0]          f_q;       // flush tap index

	logic                      tap_v_s1;
	logic signed [COEF_W-1:0]  coef_s1;
	logic                      centre_s1;
	logic                      prod_v_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;

	logic [ACC_W-1:0]          rem_q;     // magnitude, then remainder
	logic [RCP_P_W-1:0]        rcp_q;     // magnitude times reciprocal
	logic [SAMPLE_W-1:0]       quo_q;
	logic                      neg_q;

	out_word_t                 out_q;
	logic                      out_valid_q;

	// ---------------------------------------------------------------------
	// decode and conditions
	// ---------------------------------------------------------------------
	ctrl_t                     cw;
	logic                      accept;
	logic                      out_free;
	logic                      emit;
	logic                      take_jump;
	logic [IDX_W-1:0]          h_ext;
	logic [IDX_W-1:0]          h2_ext;
	logic [IDX_W-1:0]          wp_next;
	logic [WIN_W-1:0]          size_m5;
	logic [ROW_W-1:0]          row_pick;
	logic [IDX_W-1:0]          idx_a;
	logic [IDX_W-1:0]          idx_b;
	logic [SAMPLE_W-1:0]       rdata_a;
	logic [SAMPLE_W-1:0]       rdata_b;
	logic signed [PAIR_W-1:0]  pair;
	logic [ACC_W-1:0]          acc_mag;
	logic [ACC_W-1:0]          norm_ext;
	logic [SAMPLE_W-1:0]       quo_est;
	logic signed [SAMPLE_W-1:0] sat_val;
	out_word_t                 emit_word;

	assign cw         = rom(step_q);
	assign feed_stall = (step_q != ST_IDLE);
	assign accept     = feed_valid && (step_q == ST_IDLE);
	assign out_free   = !out_valid_q || !result_stall;
	assign emit       = ((cw.op == OP_EMIT_Q) || (cw.op == OP_EMIT_RAW)) && out_free;

	assign h_ext   = IDX_W'(h_q);
	assign h2_ext  = IDX_W'({h_q, 1'b0});
	assign wp_next = (wp_q == IDX_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;

	always_comb begin
		unique case (cw.cond)
			C_NONE:      take_jump = 1'b0;
			C_ALWAYS:    take_jump = 1'b1;
			C_NO_ACCEPT: take_jump = !feed_valid;
			C_K_LT_H:    take_jump = (k_q < h_ext);
			C_K_LT_2H:   take_jump = (k_q < h2_ext);
			C_J_NZ:      take_jump = (j_q != '0);
			C_PIPE_BUSY: take_jump = tap_v_s1 || prod_v_s2;
			C_OUT_BUSY:  take_jump = !out_free;
			C_NOT_END:   take_jump = !end_q;
			C_F_NZ:      take_jump = (f_q != '0);
			default:     take_jump = 1'b0;
		endcase
	end

	// window size to table row; sizes off the table or too wide fall back
	always_comb begin
		size_m5 = win_q - WIN_MIN;
		if ((win_q < WIN_MIN) || (win_q > WIN_MAX)) begin
			row_pick = ROW_7PT;
		end else begin
			row_pick = size_m5[ROW_W:1];
		end
		if (int'(row_pick) + 2 > MAX_HALF) begin
			row_pick = ROW_FALLBACK;
		end
	end

	// tap indices for the RAM read ports
	always_comb begin
		unique case (cw.asel)
			AS_TAP: begin
				idx_a = h_ext - IDX_W'(j_q);
				idx_b = h_ext + IDX_W'(j_q);
			end
			AS_EDGE: begin
				idx_a = h_ext;
				idx_b = h_ext;
			end
			AS_FLUSH: begin
				idx_a = f_q;
				idx_b = f_q;
			end
			default: begin
				idx_a = h_ext;
				idx_b = h_ext;
			end
		endcase
	end

	sgs_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_delay (
		.clk     (clk),
		.we      (accept),
		.waddr   (wp_next),
		.wdata   (feed.sample),
		.raddr_a (wrap_sub(wp_q, idx_a)),
		.raddr_b (wrap_sub(wp_q, idx_b)),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// symmetric pair sum; the centre tap counts once
	always_comb begin
		if (centre_s1) begin
			pair = PAIR_W'($signed(rdata_a));
		end else begin
			pair = PAIR_W'($signed(rdata_a)) + PAIR_W'($signed(rdata_b));
		end
	end

	assign acc_mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign norm_ext = ACC_W'(sg_norm(row_q));
	assign quo_est  = rcp_q[RCP_SHIFT +: SAMPLE_W];

	// sign and saturate the quotient magnitude
	always_comb begin
		if (!neg_q) begin
			sat_val = quo_q[SAMPLE_W-1] ? SAT_HI : $signed(quo_q);
		end else if (quo_q[SAMPLE_W-1] && (quo_q[SAMPLE_W-2:0] != '0)) begin
			sat_val = SAT_LO;
		end else begin
			sat_val = $signed(-quo_q);
		end
	end

	always_comb begin
		if (cw.op == OP_EMIT_Q) begin
			emit_word.smoothed = sat_val;
			emit_word.last_out = 1'b0;
		end else begin
			emit_word.smoothed = $signed(rdata_a);
			emit_word.last_out = (cw.lsel == LS_F_ZERO) && (f_q == '0);
		end
	end

	// ---------------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			win_q       <= WIN_RESET;
			row_q       <= ROW_FALLBACK;
			h_q         <= H_RESET;
			pos_q       <= '0;
			k_q         <= '0;
			end_q       <= 1'b0;
			wp_q        <= '0;
			j_q         <= '0;
			f_q         <= '0;
			tap_v_s1    <= 1'b0;
			prod_v_s2   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= take_jump ? cw.target : step_t'(step_q + 5'd1);

			if (cfg_wen) begin
				win_q <= cfg_wdata;
			end

			// take the word, latch the window at a block start
			if (accept) begin
				wp_q  <= wp_next;
				k_q   <= pos_q;
				end_q <= feed.block_end;
				if (pos_q == '0) begin
					row_q <= row_pick;
					h_q   <= H_W'(int'(row_pick) + 2);
				end
				if (feed.block_end) begin
					pos_q <= '0;
				end else if (pos_q < POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
			end

			if (cw.op == OP_MAC_INIT) begin
				j_q <= h_q;
			end else if ((cw.op == OP_MAC) && (j_q != '0)) begin
				j_q <= j_q - 1'b1;
			end

			tap_v_s1  <= (cw.op == OP_MAC);
			prod_v_s2 <= tap_v_s1;

			// flush taps from the oldest pending one down to the newest
			if (cw.op == OP_FLUSH_INIT) begin
				f_q <= (k_q >= h_ext) ? h_ext - 1'b1 : k_q;
			end else if ((cw.op == OP_F_DEC) && (f_q != '0)) begin
				f_q <= f_q - 1'b1;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// datapath registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		coef_s1   <= sg_coef(row_q, TAP_W'(j_q));
		centre_s1 <= (j_q == '0);
		prod_s2   <= coef_s1 * pair;

		if (cw.op == OP_MAC_INIT) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end

		// magnitude over the row normaliser: reciprocal estimate, then one
		// compare against the remainder lifts it to the exact quotient
		if (cw.op == OP_DIV_INIT) begin
			rem_q <= acc_mag;
			neg_q <= acc_q[ACC_W-1];
		end else if (cw.op == OP_DIV) begin
			rcp_q <= RCP_P_W'(rem_q) * RCP_P_W'(sg_recip(row_q));
		end else if (cw.op == OP_DIV_EST) begin
			quo_q <= quo_est;
			rem_q <= rem_q - ACC_W'(quo_est) * norm_ext;
		end else if (cw.op == OP_DIV_FIX) begin
			if (rem_q >= norm_ext) begin
				quo_q <= quo_q + 1'b1;
			end
		end

		if (emit) begin
			out_q <= emit_word;
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule

`default_nettype wire
